### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst_n is low.
// The enclosing scope must provide clk and rst_n.
`define ECD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge.
`define ECD_ASSERT_NEVER(lbl, cond, msg) \
  `ECD_ASSERT(lbl, !(cond), msg)

`endif

### design/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Constants, stage payload types and a shared arithmetic helper for the
// epoch-seconds to civil-date converter.
// ----------------------------------------------------------------------------
package ecd_pkg;

  // Seconds per day is 2^7 * 675: shift by 7, then reciprocal multiply by 1/675.
  // ceil(2^35 / 675); exact for every 25-bit dividend.
  localparam int unsigned     SecsShift    = 7;
  localparam logic [25:0]     Recip675     = 26'd50903317;

  // Shift of the day count so that day 0 is 0000-03-01.
  localparam logic [19:0]     MarchShift   = 20'd719468;

  // Shifted day counts of a 32-bit input lie in eras 4 and 5 only.
  localparam logic [19:0]     Era4Start    = 20'd584388;
  localparam logic [19:0]     Era5Start    = 20'd730485;
  localparam logic [11:0]     Era4Year     = 12'd1600;
  localparam logic [11:0]     Era5Year     = 12'd2000;

  // Century and quad-century boundaries inside an era.
  localparam logic [17:0]     Doe1Cent     = 18'd36524;
  localparam logic [17:0]     Doe2Cent     = 18'd73048;
  localparam logic [17:0]     Doe3Cent     = 18'd109572;
  localparam logic [17:0]     DoeLastDay   = 18'd146096;

  // ceil(2^26 / 365); exact for dividends below 2^18.
  localparam logic [17:0]     Recip365     = 18'd183860;
  // ceil(2^19 / 153); exact for dividends up to 1827.
  localparam logic [11:0]     Recip153     = 12'd3427;
  // ceil(2^13 / 5); exact for dividends up to 1685.
  localparam logic [10:0]     Recip5       = 11'd1639;

  localparam logic [8:0]      DaysPerYear  = 9'd365;
  localparam logic [7:0]      DaysPer5Mon  = 8'd153;

  // Stage 1 result: whole days since the epoch.
  typedef struct packed {
    logic [15:0] day_number;
    logic        no_clock;
  } ecd_day_t;

  // Era stage result: day of era and year of era.
  typedef struct packed {
    logic [15:0] day_number;
    logic        no_clock;
    logic        era_hi;     // 1: era 5, 0: era 4
    logic [17:0] doe;
    logic [8:0]  yoe;
  } ecd_yoe_t;

  // Final transaction payload.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] day_number;
    logic        no_clock;
  } ecd_result_t;

  // Exact x / 365 for any 18-bit x (quotient at most 718).
  function automatic logic [9:0] div365(input logic [17:0] x);
    logic [35:0] prod;
    prod = 36'(x) * 36'(Recip365);
    return prod[35:26];
  endfunction

endpackage

### design/ecd_if.sv
// ----------------------------------------------------------------------------
// ecd_if
// Valid/ready channels of the converter: timestamp in, calendar date out.
// ----------------------------------------------------------------------------
interface ecd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [15:0] day_number;
  logic        no_clock;

  modport source (output valid, output year, output month, output day,
                  output day_number, output no_clock, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input day_number, input no_clock, output ready);
endinterface

### design/ecd_days.sv
// ----------------------------------------------------------------------------
// ecd_days
// Pipeline stage 1: seconds to whole days by shift and reciprocal multiply,
// plus the unset-clock flag.
// ----------------------------------------------------------------------------
module ecd_days (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      in_secs,
  output logic             out_valid,
  input  logic             out_ready,
  output ecd_pkg::ecd_day_t out_data
);
  import ecd_pkg::*;

  logic        v_r;
  ecd_day_t    data_r;
  ecd_day_t    data_nxt;
  logic [50:0] prod;

  // (secs >> 7) / 675 == secs / 86400
  always_comb begin
    prod                = 51'(in_secs[31:SecsShift]) * 51'(Recip675);
    data_nxt.day_number = prod[50:35];
    data_nxt.no_clock   = (in_secs == 32'd0);
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = data_r;

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### design/ecd_era.sv
// ----------------------------------------------------------------------------
// ecd_era
// Pipeline stages 2..4: era and day of era, the leap-day corrections, and
// the year of era.
// ----------------------------------------------------------------------------
module ecd_era (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ecd_pkg::ecd_day_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ecd_pkg::ecd_yoe_t out_data
);
  import ecd_pkg::*;

  logic        s2_v_r, s3_v_r, s4_v_r;
  logic        s2_rdy, s3_rdy, s4_rdy;

  ecd_yoe_t    s2_r, s2_nxt;
  ecd_yoe_t    s3_r;
  logic [6:0]  s3_q1460_r, s3_q1460_nxt;
  ecd_yoe_t    s4_r, s4_nxt;

  logic [19:0] z;
  logic [9:0]  q1460_full;
  logic [2:0]  q36524;
  logic        q146096;
  logic [17:0] yoe_num;
  logic [9:0]  yoe_full;

  // Ready chain: a stage moves when it is empty or its successor moves
  assign s4_rdy   = !s4_v_r || out_ready;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign in_ready = s2_rdy;

  // Stage 2: shift to March-based count, pick era, day of era
  always_comb begin
    z                 = 20'(in_data.day_number) + MarchShift;
    s2_nxt            = '0;
    s2_nxt.day_number = in_data.day_number;
    s2_nxt.no_clock   = in_data.no_clock;
    s2_nxt.era_hi     = (z >= Era5Start);
    s2_nxt.doe        = 18'(z - (s2_nxt.era_hi ? Era5Start : Era4Start));
  end

  // Stage 3: doe / 1460 as (doe >> 2) / 365
  always_comb begin
    q1460_full   = div365({2'b00, s2_r.doe[17:2]});
    s3_q1460_nxt = q1460_full[6:0];
  end

  // Stage 4: drop leap days, then year of era
  always_comb begin
    if (s3_r.doe >= DoeLastDay) begin
      q36524 = 3'd4;
    end else if (s3_r.doe >= Doe3Cent) begin
      q36524 = 3'd3;
    end else if (s3_r.doe >= Doe2Cent) begin
      q36524 = 3'd2;
    end else if (s3_r.doe >= Doe1Cent) begin
      q36524 = 3'd1;
    end else begin
      q36524 = 3'd0;
    end
    q146096  = (s3_r.doe >= DoeLastDay);
    yoe_num  = s3_r.doe - 18'(s3_q1460_r) + 18'(q36524) - 18'(q146096);
    yoe_full = div365(yoe_num);
    s4_nxt     = s3_r;
    s4_nxt.yoe = yoe_full[8:0];
  end

  assign out_valid = s4_v_r;
  assign out_data  = s4_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s2_rdy) s2_v_r <= in_valid;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s2_rdy && in_valid) begin
      s2_r <= s2_nxt;
    end
    if (s3_rdy && s2_v_r) begin
      s3_r       <= s2_r;
      s3_q1460_r <= s3_q1460_nxt;
    end
    if (s4_rdy && s3_v_r) begin
      s4_r <= s4_nxt;
    end
  end

endmodule

### design/ecd_month.sv
// ----------------------------------------------------------------------------
// ecd_month
// Pipeline stages 5..7: day of year, March-based month, then calendar
// month, day and year into the output register.
// ----------------------------------------------------------------------------
module ecd_month (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ecd_pkg::ecd_yoe_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ecd_pkg::ecd_result_t out_data
);
  import ecd_pkg::*;

  logic        s5_v_r, s6_v_r, s7_v_r;
  logic        s5_rdy, s6_rdy, s7_rdy;

  ecd_yoe_t    s5_r;
  logic [8:0]  s5_doy_r, s5_doy_nxt;
  ecd_yoe_t    s6_r;
  logic [8:0]  s6_doy_r;
  logic [3:0]  s6_mp_r, s6_mp_nxt;
  ecd_result_t s7_r, s7_nxt;

  logic [1:0]  yoe_c;
  logic [17:0] yr_days;
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [10:0] d_num;
  logic [21:0] d_prod;
  logic [8:0]  d_off;
  logic [3:0]  mon;

  assign s7_rdy   = !s7_v_r || out_ready;
  assign s6_rdy   = !s6_v_r || s7_rdy;
  assign s5_rdy   = !s5_v_r || s6_rdy;
  assign in_ready = s5_rdy;

  // Stage 5: day of year = doe - (365*yoe + yoe/4 - yoe/100)
  always_comb begin
    if (in_data.yoe >= 9'd300) begin
      yoe_c = 2'd3;
    end else if (in_data.yoe >= 9'd200) begin
      yoe_c = 2'd2;
    end else if (in_data.yoe >= 9'd100) begin
      yoe_c = 2'd1;
    end else begin
      yoe_c = 2'd0;
    end
    yr_days    = 18'(in_data.yoe) * 18'(DaysPerYear) + 18'(in_data.yoe[8:2]) - 18'(yoe_c);
    s5_doy_nxt = 9'(in_data.doe - yr_days);
  end

  // Stage 6: March-based month = (5*doy + 2) / 153
  always_comb begin
    mp_num    = 11'(s5_doy_r) * 11'd5 + 11'd2;
    mp_prod   = 23'(mp_num) * 23'(Recip153);
    s6_mp_nxt = mp_prod[22:19];
  end

  // Stage 7: day, calendar month, year
  always_comb begin
    d_num  = 11'(s6_mp_r) * 11'(DaysPer5Mon) + 11'd2;
    d_prod = 22'(d_num) * 22'(Recip5);
    d_off  = d_prod[21:13];
    mon    = (s6_mp_r < 4'd10) ? (s6_mp_r + 4'd3) : (s6_mp_r - 4'd9);
    s7_nxt.day        = 5'(s6_doy_r - d_off + 9'd1);
    s7_nxt.month      = mon;
    s7_nxt.year       = 12'(s6_r.yoe) + (s6_r.era_hi ? Era5Year : Era4Year)
                        + 12'(mon <= 4'd2);
    s7_nxt.day_number = s6_r.day_number;
    s7_nxt.no_clock   = s6_r.no_clock;
  end

  assign out_valid = s7_v_r;
  assign out_data  = s7_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (s5_rdy) s5_v_r <= in_valid;
      if (s6_rdy) s6_v_r <= s5_v_r;
      if (s7_rdy) s7_v_r <= s6_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s5_rdy && in_valid) begin
      s5_r     <= in_data;
      s5_doy_r <= s5_doy_nxt;
    end
    if (s6_rdy && s5_v_r) begin
      s6_r     <= s5_r;
      s6_doy_r <= s5_doy_r;
      s6_mp_r  <= s6_mp_nxt;
    end
    if (s7_rdy && s6_v_r) begin
      s7_r <= s7_nxt;
    end
  end

endmodule

### design/epoch_seconds_to_civil_date_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date_unit
// Converts 32-bit Unix seconds to Gregorian year, month, day and day count.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per clock in and out while the output is
// not stalled. An accepted input is registered in stage 1 and then passes
// through stages 2 to 7; the stage 7 register drives the output. Each of the
// seven stages holds constant reciprocal multiplies, compare/subtract steps
// or both (seconds to days, era select, two divide-by-365 steps, day of year,
// March month, final date). Back-pressure on the output stalls the pipeline
// stage by stage; empty stages keep filling, so in_chan.ready stays high while
// any bubble remains. no_clock flags a zero input; the date fields then read
// 1970-01-01 with day_number 0.
module epoch_seconds_to_civil_date_unit (
  input  logic      clk,
  input  logic      rst_n,
  ecd_in_if.sink    in_chan,
  ecd_out_if.source out_chan
);
  import ecd_pkg::*;

  logic        days_valid, days_ready;
  ecd_day_t    days_data;
  logic        era_valid, era_ready;
  ecd_yoe_t    era_data;
  ecd_result_t res_data;

  // Seconds to days
  ecd_days u_days (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_secs   (in_chan.epoch_seconds),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .out_data  (days_data)
  );

  // Days to era and year of era
  ecd_era u_era (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (days_valid),
    .in_ready  (days_ready),
    .in_data   (days_data),
    .out_valid (era_valid),
    .out_ready (era_ready),
    .out_data  (era_data)
  );

  // Year of era to calendar date
  ecd_month u_month (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (era_valid),
    .in_ready  (era_ready),
    .in_data   (era_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (res_data)
  );

  assign out_chan.year       = res_data.year;
  assign out_chan.month      = res_data.month;
  assign out_chan.day        = res_data.day;
  assign out_chan.day_number = res_data.day_number;
  assign out_chan.no_clock   = res_data.no_clock;

endmodule

### design/ecd_checker.sv
// ----------------------------------------------------------------------------
// ecd_checker
// Port-level checks of the converter output, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [15:0] out_day_number,
  input logic        out_no_clock
);

  // A stalled result transaction holds its payload
  `ECD_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_year) && $stable(out_month) && $stable(out_day) && $stable(out_day_number) && $stable(out_no_clock)), "output changed while stalled")

  // Month and day are legal calendar values
  `ECD_ASSERT_NEVER(a_date_range, out_valid && (out_month == 4'd0 || out_month > 4'd12 || out_day == 5'd0), "illegal month or day")

  // Year stays inside the span of a 32-bit timestamp
  `ECD_ASSERT_NEVER(a_year_range, out_valid && (out_year < 12'd1970 || out_year > 12'd2106), "year out of range")

  // Unset clock reports the epoch date
  `ECD_ASSERT(a_no_clock_date, (out_valid && out_no_clock) |-> (out_day_number == 16'd0 && out_year == 12'd1970 && out_month == 4'd1 && out_day == 5'd1), "unset clock date wrong")

endmodule

bind epoch_seconds_to_civil_date_unit ecd_checker u_ecd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_year       (out_chan.year),
  .out_month      (out_chan.month),
  .out_day        (out_chan.day),
  .out_day_number (out_chan.day_number),
  .out_no_clock   (out_chan.no_clock)
);

### tb/sv/epoch_seconds_to_civil_date_unit_tb.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date_unit_tb
// Self-checking bench for the timestamp to calendar date converter. Timestamps
// go in over the input channel: first a directed set of calendar corners,
// then random values. A scoreboard predicts year, month, day, day count and
// the unset-clock flag for each accepted timestamp, and checks every returned
// date in order. Both channel sides idle at random except in the last phase.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_date_unit_tb;
  import ecd_pkg::*;

  localparam int unsigned SecsPerDay     = 86400;
  localparam int unsigned DaysToMarch0   = 719468;
  localparam int unsigned DaysInEra      = 146097;
  localparam int unsigned RandomPerPhase = 300;
  localparam int unsigned StallLimit     = 4000;
  localparam int unsigned DrainCycles    = 20;

  // Predicts dates for accepted timestamps and checks returned dates in order
  class civil_date_scoreboard;
    ecd_result_t date_queue[$];
    int unsigned error_count;
    int unsigned dates_checked;
    int unsigned unset_clock_seen;
    int unsigned leap_days_seen;

    function new();
      error_count      = 0;
      dates_checked    = 0;
      unset_clock_seen = 0;
      leap_days_seen   = 0;
    endfunction

    // Day count, then March-based era / year-of-era / day-of-year split
    function ecd_result_t civil_date_of(input logic [31:0] secs);
      ecd_result_t date;
      int unsigned days, shifted, era, day_of_era, year_of_era;
      int unsigned yr, day_of_year, march_month, mday, mon;
      days        = secs / SecsPerDay;
      shifted     = days + DaysToMarch0;
      era         = shifted / DaysInEra;
      day_of_era  = shifted - era * DaysInEra;
      year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                     - day_of_era / 146096) / 365;
      yr          = year_of_era + era * 400;
      day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4
                                  - year_of_era / 100);
      march_month = (5 * day_of_year + 2) / 153;
      mday        = day_of_year - (153 * march_month + 2) / 5 + 1;
      mon         = (march_month < 10) ? march_month + 3 : march_month - 9;
      if (mon <= 2) yr = yr + 1;
      date.year       = yr[11:0];
      date.month      = mon[3:0];
      date.day        = mday[4:0];
      date.day_number = days[15:0];
      date.no_clock   = (secs == 32'd0);
      return date;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      error_count++;
    endtask

    function void note_timestamp(input logic [31:0] secs);
      date_queue.push_back(civil_date_of(secs));
    endfunction

    task check_date(input ecd_result_t got);
      ecd_result_t want;
      if (date_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected date %0d-%0d-%0d", got.year, got.month,
                                  got.day));
        return;
      end
      want = date_queue.pop_front();
      dates_checked++;
      if (got.no_clock) unset_clock_seen++;
      if (got.month == 4'd2 && got.day == 5'd29) leap_days_seen++;
      if (got.year !== want.year)
        report_mismatch($sformatf("year %0d, expected %0d", got.year, want.year));
      if (got.month !== want.month)
        report_mismatch($sformatf("month %0d, expected %0d", got.month, want.month));
      if (got.day !== want.day)
        report_mismatch($sformatf("day %0d, expected %0d", got.day, want.day));
      if (got.day_number !== want.day_number)
        report_mismatch($sformatf("day_number %0d, expected %0d", got.day_number,
                                  want.day_number));
      if (got.no_clock !== want.no_clock)
        report_mismatch($sformatf("no_clock %0b, expected %0b", got.no_clock,
                                  want.no_clock));
    endtask

    function int unsigned pending();
      return date_queue.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ecd_in_if  in_chan ();
  ecd_out_if out_chan ();

  epoch_seconds_to_civil_date_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  civil_date_scoreboard date_sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned timestamps_sent;
  int unsigned quiet_cycles;
  ecd_result_t seen_date;

  logic [31:0] corner_secs[$] = '{
    32'd0, 32'd1, 32'd59, 32'd86399, 32'd86400, 32'd86401,
    32'd31535999, 32'd31536000,         // end of 1970, start of 1971
    32'd68169600, 32'd68256000,         // 1972 leap day, next day
    32'd946684799, 32'd946684800,       // millennium rollover
    32'd951782400, 32'd951868800,       // 2000 leap day (divisible by 400)
    32'd2147483647, 32'd2147483648,     // signed 32-bit rollover
    32'd4107542399, 32'd4107542400,     // 2100 has no Feb 29
    32'd4294944000, 32'hFFFF_FFFF,      // last representable day
    32'h5555_5555, 32'hAAAA_AAAA
  };

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Known input levels from time zero
  initial begin
    in_chan.valid         = 1'b0;
    in_chan.epoch_seconds = 32'd0;
    out_chan.ready        = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_date.year       = out_chan.year;
      seen_date.month      = out_chan.month;
      seen_date.day        = out_chan.day;
      seen_date.day_number = out_chan.day_number;
      seen_date.no_clock   = out_chan.no_clock;
      date_sb.check_date(seen_date);
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One timestamp transaction; entered and left at a falling edge
  task automatic send_timestamp(input logic [31:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.epoch_seconds <= secs;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    date_sb.note_timestamp(secs);
    timestamps_sent++;
    @(negedge clk);
  endtask

  // Mostly full-range values, plus day edges, early dates, the top end and zero
  function automatic logic [31:0] pick_timestamp();
    longint unsigned secs;
    case ($urandom_range(9))
      6: begin
        secs = 64'($urandom_range(49710)) * 64'(SecsPerDay)
               + 64'($urandom_range(1) ? 0 : SecsPerDay - 1);
        if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;
      end
      7: secs = 64'($urandom_range(3 * SecsPerDay * 366));
      8: secs = 64'hFFFF_FFFF - 64'($urandom_range(10_000_000));
      9: secs = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(3 * SecsPerDay));
      default: secs = 64'($urandom);
    endcase
    return secs[31:0];
  endfunction

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RandomPerPhase) send_timestamp(pick_timestamp());
  endtask

  // Main sequence
  initial begin
    date_sb         = new();
    timestamps_sent = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 11;
    recv_stall_pct  = 83;
    rst_n           = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_secs[i]) send_timestamp(corner_secs[i]);
    run_random_phase(11, 83);
    run_random_phase(83, 11);
    run_random_phase(0, 0);
    in_chan.valid <= 1'b0;

    while (date_sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d timestamps, %0d dates checked in order", timestamps_sent,
             date_sb.dates_checked);
    $display("Covered %0d unset-clock inputs and %0d leap days, up to 2106-02-07",
             date_sb.unset_clock_seen, date_sb.leap_days_seen);
    if (date_sb.error_count == 0 && date_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/ecd_pkg.sv
design/ecd_if.sv
design/ecd_days.sv
design/ecd_era.sv
design/ecd_month.sv
design/epoch_seconds_to_civil_date_unit.sv
design/ecd_checker.sv
tb/sv/epoch_seconds_to_civil_date_unit_tb.sv
